/* sv/mavw_pkg.sv */
package mavw_pkg;

  // window size register
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd3;

  // result word
  localparam int AVG_W = 48;

endpackage

/* sv/mavw_ram.sv */
module mavw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/mavw_div.sv */
module mavw_div #(
  parameter int DVD_W = 54,
  parameter int DSR_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  // dividend bits leave at the top, quotient bits enter at the bottom
  logic [DVD_W-1:0]  sh_r, sh_nxt;
  logic [DSR_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [DSR_W:0] trial;
  logic [DSR_W:0] diff;
  logic           ge;

  always_comb begin
    trial = {rem_r, sh_r[DVD_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = trial >= {1'b0, divisor};

    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (start) begin
      sh_nxt   = dividend;
      rem_nxt  = '0;
      step_nxt = STEP_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // restoring step, remainder stays below the divisor
      rem_nxt  = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      sh_nxt   = {sh_r[DVD_W-2:0], ge};
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = sh_r;

endmodule

/* sv/moving_average_window_top.sv */
// channel | ports                                   | direction
// in      | in_valid, in_ready, in_sample           | sample word in
// out     | out_valid, out_ready, out_average,      | average word out
//         | out_invalid                             |
// cfg     | cfg_valid, cfg_ready, cfg_window_size   | window size write
//
// one sample word is in flight at a time: after accept it passes the subtract, add, load,
// divide and finish states, with the bit-serial divider giving one quotient bit a cycle,
// and the next is accepted once back in idle; a zero window goes from accept straight to finish.
// no clearing pass on the ring: the fill count keeps unwritten slots from entering the sum.
// reset is synchronous, active low; a window size write is taken only while idle.
// a sample taken while the last average waits holds before the output until that word leaves
module moving_average_window_top #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 32,
  parameter int FRAC_BITS    = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]  in_sample,

  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [mavw_pkg::AVG_W-1:0] out_average,
  output logic                            out_invalid,

  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mavw_pkg::CFG_W-1:0]      cfg_window_size
);

  localparam int PTR_W = MAX_WINDOW > 1 ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
  localparam int DVD_W = SUM_W + FRAC_BITS;
  localparam int QX_W  = DVD_W > mavw_pkg::AVG_W ? DVD_W : mavw_pkg::AVG_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUB,
    S_ADD,
    S_LOAD,
    S_DIV,
    S_FIN
  } state_t;

  state_t                            state_r, state_nxt;
  logic [mavw_pkg::CFG_W-1:0]        win_r, win_nxt;
  logic [PTR_W-1:0]                  wp_r, wp_nxt;
  logic [CNT_W-1:0]                  fill_r, fill_nxt;
  logic signed [SUM_W-1:0]           sum_r, sum_nxt;
  logic signed [SAMPLE_WIDTH-1:0]    sample_r, sample_nxt;
  logic                              inv_r, inv_nxt;
  logic                              neg_r, neg_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [mavw_pkg::AVG_W-1:0]        out_avg_r, out_avg_nxt;
  logic                              out_inv_r, out_inv_nxt;

  logic [CNT_W-1:0]  w_eff;
  logic              in_fire;
  logic              cfg_fire;
  logic              full;
  logic [PTR_W:0]    wp_inc;
  logic [SUM_W-1:0]  mag;
  logic [QX_W-1:0]   q_ext;
  logic [QX_W-1:0]   avg_full;

  logic              ram_we;
  logic [SAMPLE_WIDTH-1:0] ram_rdata;

  logic              div_start;
  logic              div_done;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVD_W-1:0]  div_q;

  // window saturates at the ring depth
  always_comb begin
    if (32'(win_r) > 32'(MAX_WINDOW)) begin
      w_eff = CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = CNT_W'(win_r);
    end
  end

  // a window write goes ahead of a sample in the same cycle
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign full      = fill_r >= w_eff;
  assign wp_inc    = {1'b0, wp_r} + 1'b1;
  assign mag       = sum_r[SUM_W-1] ? unsigned'(SUM_W'(-sum_r)) : unsigned'(sum_r);
  assign div_dvd   = DVD_W'(mag) << FRAC_BITS;
  assign div_start = (state_r == S_LOAD);
  assign ram_we    = (state_r == S_SUB);
  assign q_ext     = QX_W'(div_q);
  assign avg_full  = neg_r ? (-q_ext) : q_ext;

  mavw_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (sample_r),
    .re    (in_fire),
    .raddr (wp_r),
    .rdata (ram_rdata)
  );

  mavw_div #(
    .DVD_W (DVD_W),
    .DSR_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (fill_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt     = state_r;
    win_nxt       = win_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    sample_nxt    = sample_r;
    inv_nxt       = inv_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    out_avg_nxt   = out_avg_r;
    out_inv_nxt   = out_inv_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_fire) begin
      win_nxt  = cfg_window_size;
      wp_nxt   = '0;
      fill_nxt = '0;
      sum_nxt  = '0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          sample_nxt = in_sample;
          inv_nxt    = (w_eff == '0);
          state_nxt  = (w_eff == '0) ? S_FIN : S_SUB;
        end
      end
      S_SUB: begin
        // evicted sample read at accept, new one takes its slot
        if (full) begin
          sum_nxt  = sum_r - SUM_W'($signed(ram_rdata));
          fill_nxt = w_eff;
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
        wp_nxt    = (32'(wp_inc) == 32'(w_eff)) ? '0 : wp_inc[PTR_W-1:0];
        state_nxt = S_ADD;
      end
      S_ADD: begin
        sum_nxt   = sum_r + SUM_W'(sample_r);
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        neg_nxt   = sum_r[SUM_W-1];
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_inv_nxt   = inv_r;
          out_avg_nxt   = inv_r ? '0 : avg_full[mavw_pkg::AVG_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_r       <= mavw_pkg::CFG_RESET;
      wp_r        <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_r       <= win_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sample_r  <= sample_nxt;
    inv_r     <= inv_nxt;
    neg_r     <= neg_nxt;
    out_avg_r <= out_avg_nxt;
    out_inv_r <= out_inv_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_average = out_avg_r;
  assign out_invalid = out_inv_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= w_eff)
    else $error("fill count beyond window");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (w_eff != '0) |-> (CNT_W'(wp_r) < w_eff))
    else $error("write pointer beyond window");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside of division");

  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_invalid) |-> (out_average == '0))
    else $error("invalid word with nonzero average");

endmodule

/* verif/moving_average_window_checker.sv */
module moving_average_window_checker #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 32,
  parameter int FRAC_BITS    = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,

  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [mavw_pkg::AVG_W-1:0] out_average,
  input  logic                           out_invalid,

  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [mavw_pkg::CFG_W-1:0]     cfg_window_size,

  output int                             avg_waiting,
  output int                             mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SUM_W = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
  localparam int DIV_W = SUM_W + FRAC_BITS;

  typedef struct packed {
    logic signed [mavw_pkg::AVG_W-1:0] average;
    logic                              invalid;
  } avg_word_t;

  logic [mavw_pkg::CFG_W-1:0]     win_reg;
  logic signed [SAMPLE_WIDTH-1:0] ring [MAX_WINDOW];
  int unsigned                    wr_ptr;
  int unsigned                    fill;
  logic signed [SUM_W-1:0]        win_sum;
  avg_word_t                      avg_expected [$];
  int                             err_cnt = 0;
  int                             waiting_cnt = 0;

  assign avg_waiting    = waiting_cnt;
  assign mismatch_count = err_cnt;

  // push one sample into the window and work out its average word
  function automatic avg_word_t slide_window(logic signed [SAMPLE_WIDTH-1:0] s);
    int unsigned      w;
    int unsigned      slot;
    logic [SUM_W-1:0] mag;
    logic [DIV_W-1:0] quo;
    avg_word_t        r;
    w = (win_reg > MAX_WINDOW) ? MAX_WINDOW : win_reg;
    r.average = '0;
    r.invalid = 1'b1;
    if (w == 0) begin
      return r;
    end
    slot = wr_ptr % w;
    if (fill >= w) begin
      win_sum = win_sum - ring[slot];
      fill = w;
    end else begin
      fill++;
    end
    win_sum = win_sum + s;
    ring[slot] = s;
    wr_ptr = (slot + 1) % w;
    // divide the magnitude, then put the sign back: truncates toward zero
    mag = (win_sum < 0) ? -win_sum : win_sum;
    quo = (DIV_W'(mag) << FRAC_BITS) / fill;
    if (win_sum < 0) begin
      quo = -quo;
    end
    r.average = quo[mavw_pkg::AVG_W-1:0];
    r.invalid = 1'b0;
    return r;
  endfunction

  task automatic flag_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  always @(posedge clk) begin
    avg_word_t want;
    if (!rst_n) begin
      win_reg = mavw_pkg::CFG_RESET;
      wr_ptr  = 0;
      fill    = 0;
      win_sum = '0;
      avg_expected.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        win_reg = cfg_window_size;
        wr_ptr  = 0;
        fill    = 0;
        win_sum = '0;
      end
      // output first: a word leaving now belongs to an older sample
      if (out_valid && out_ready) begin
        if (avg_expected.size() == 0) begin
          flag_error($sformatf("average word with none expected: average %0d invalid %0b",
                               out_average, out_invalid));
        end else begin
          want = avg_expected.pop_front();
          if (out_average !== want.average) begin
            flag_error($sformatf("average expected %0d got %0d", want.average, out_average));
          end
          if (out_invalid !== want.invalid) begin
            flag_error($sformatf("invalid expected %0b got %0b", want.invalid, out_invalid));
          end
        end
      end
      if (in_valid && in_ready) begin
        avg_expected.push_back(slide_window(in_sample));
      end
    end
    waiting_cnt <= avg_expected.size();
  end

endmodule

/* verif/moving_average_window_top_tb.sv */
module moving_average_window_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_WIDTH = 32;
  localparam int FRAC_BITS    = 16;
  localparam int RANDOM_ITEMS = 1000;

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = 32'sh7fff_ffff;
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = 32'sh8000_0000;

  typedef enum int {MIXED, ALL_MAX, ALL_MIN} sample_mix_t;

  logic                                clk;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic signed [SAMPLE_WIDTH-1:0]      in_sample = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [mavw_pkg::AVG_W-1:0]   out_average;
  logic                                out_invalid;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [mavw_pkg::CFG_W-1:0]          cfg_window_size = '0;

  int avg_waiting;
  int mismatch_count;
  int n_sent = 0;
  int send_idle = 0;
  int recv_idle = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  moving_average_window_top #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_average    (out_average),
    .out_invalid    (out_invalid),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_window_size(cfg_window_size)
  );

  moving_average_window_checker #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_average    (out_average),
    .out_invalid    (out_invalid),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_window_size(cfg_window_size),
    .avg_waiting    (avg_waiting),
    .mismatch_count (mismatch_count)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // returns at the accepting edge with valid still high
  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] v);
    if (n_sent < RANDOM_ITEMS / 3) begin
      send_idle = 16;
      recv_idle = 64;
    end else if (n_sent < 2 * RANDOM_ITEMS / 3) begin
      send_idle = 64;
      recv_idle = 16;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= v;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (avg_waiting != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [mavw_pkg::CFG_W-1:0] w);
    drain();
    cfg_valid       <= 1'b1;
    cfg_window_size <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample(sample_mix_t mix);
    int unsigned k;
    if (mix == ALL_MAX) return SAMPLE_MAX;
    if (mix == ALL_MIN) return SAMPLE_MIN;
    k = $urandom_range(9);
    if (k == 0) return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
    // small values make the fraction bits and truncation visible
    if (k <= 3) return $signed($urandom_range(200)) - 100;
    return $urandom();
  endfunction

  function automatic logic [mavw_pkg::CFG_W-1:0] pick_window();
    case ($urandom_range(7))
      0:       return '0;
      1:       return mavw_pkg::CFG_W'(1);
      2:       return mavw_pkg::CFG_W'(MAX_WINDOW);
      3:       return '1;
      4:       return mavw_pkg::CFG_W'($urandom_range(5, 2));
      default: return mavw_pkg::CFG_W'($urandom_range(127, 1));
    endcase
  endfunction

  initial begin
    logic [mavw_pkg::CFG_W-1:0] w;
    int                         eff;
    int                         n;
    sample_mix_t                mix;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset window of three: extremes, eviction and wrap
    send_sample(SAMPLE_MAX); send_sample(SAMPLE_MAX); send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN); send_sample(0);          send_sample(-1);
    send_sample(1);          send_sample(3);
    write_window(mavw_pkg::CFG_W'(1));
    send_sample(SAMPLE_MIN); send_sample(SAMPLE_MAX); send_sample(-1);
    // zero window: invalid word, sample dropped
    write_window('0);
    send_sample(SAMPLE_MAX); send_sample(SAMPLE_MIN);
    write_window(mavw_pkg::CFG_W'(MAX_WINDOW));
    send_sample(SAMPLE_MIN); send_sample(5);          send_sample(-7);
    // above the largest window it saturates
    write_window('1);
    send_sample(SAMPLE_MAX); send_sample(-3);         send_sample(2);
    write_window(mavw_pkg::CFG_W'(2));
    send_sample(1);          send_sample(0);          send_sample(-1);
    send_sample(-2);

    n_sent = 0;
    while (n_sent < RANDOM_ITEMS) begin
      w   = pick_window();
      eff = (w > MAX_WINDOW) ? MAX_WINDOW : w;
      n   = (w == 0) ? $urandom_range(6, 2) : 2 * eff + $urandom_range(12, 1);
      case ($urandom_range(5))
        0:       mix = ALL_MAX;
        1:       mix = ALL_MIN;
        default: mix = MIXED;
      endcase
      write_window(w);
      repeat (n) begin
        send_sample(pick_sample(mix));
        if ($urandom_range(63) == 0) drain();
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && avg_waiting == 0) begin
      $display("** moving_average_window_top: PASSED **");
    end else begin
      $display("** moving_average_window_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d average words outstanding", avg_waiting);
    $display("** moving_average_window_top: FAILED **");
    $finish;
  end

endmodule

/* filelist.f */
sv/mavw_pkg.sv
sv/mavw_ram.sv
sv/mavw_div.sv
sv/moving_average_window_top.sv
verif/moving_average_window_checker.sv
verif/moving_average_window_top_tb.sv
